// ----- rtl/ucl_pkg.sv -----
`default_nettype none

package ucl_pkg;

  localparam int unsigned MAX_MSG_LEN_DEFAULT = 64;

  // Keyword table geometry
  localparam int unsigned KW_NUM   = 14;
  localparam int unsigned KW_CHARS = 18;
  localparam int unsigned KW_IDX_W = 4;
  localparam int unsigned KW_POS_W = 5;

  // Configuration register indexes
  localparam logic [1:0] CFG_ECHO_MODE = 2'd0;
  localparam logic [1:0] CFG_WORD_SEP  = 2'd1;
  localparam logic [1:0] CFG_MSG_END   = 2'd2;
  localparam logic [1:0] CFG_LINE_FEED = 2'd3;

  localparam logic       ECHO_MODE_RST = 1'b1;
  localparam logic [7:0] WORD_SEP_RST  = 8'd32;
  localparam logic [7:0] MSG_END_RST   = 8'd13;
  localparam logic [7:0] LINE_FEED_RST = 8'd10;

  // Result kinds
  localparam logic KIND_ECHO   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // Command codes
  localparam logic [3:0] CMD_NONE      = 4'd0;
  localparam logic [3:0] CMD_ON        = 4'd1;
  localparam logic [3:0] CMD_OFF       = 4'd2;
  localparam logic [3:0] CMD_VOLTAGE   = 4'd3;
  localparam logic [3:0] CMD_CURRENT   = 4'd4;
  localparam logic [3:0] CMD_LIMIT     = 4'd5;
  localparam logic [3:0] CMD_BUTTON    = 4'd6;
  localparam logic [3:0] CMD_ENCODER   = 4'd7;
  localparam logic [3:0] CMD_PROFILING = 4'd8;

  // Status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_MISSING = 2'd1;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

  typedef enum logic [1:0] {
    ARG_NONE,
    ARG_BUTTON,
    ARG_UNSIGNED,
    ARG_SIGNED
  } arg_kind_e;

  typedef enum logic [2:0] {
    NUM_SIGN,
    NUM_AFTER_SIGN,
    NUM_ZERO,
    NUM_HEX_FIRST,
    NUM_DIGITS,
    NUM_DONE
  } num_phase_e;

  typedef enum logic [1:0] {
    BASE_NONE,
    BASE_OCT,
    BASE_DEC,
    BASE_HEX
  } num_base_e;

  // Keyword text, right-justified: the last character sits in the low byte
  localparam logic [8*KW_CHARS-1:0] KW_TEXT [KW_NUM] = '{
    "on", "off", {"set", "_voltage"}, {"set", "_current"}, {"set", "_current_limit"},
    "btn_esc", "btn_ok", {"btn", "_left"}, {"btn", "_right"}, "btn_on", "btn_off",
    {"push", "_encoder"}, {"encoder", "_delta"}, {"get_time", "_profiling"}
  };

  localparam logic [KW_POS_W-1:0] KW_LEN [KW_NUM] = '{
    5'd2, 5'd3, 5'd11, 5'd11, 5'd17, 5'd7, 5'd6, 5'd8, 5'd9, 5'd6, 5'd7,
    5'd12, 5'd13, 5'd18
  };

  localparam logic [3:0] KW_CMD [KW_NUM] = '{
    CMD_ON, CMD_OFF, CMD_VOLTAGE, CMD_CURRENT, CMD_LIMIT,
    CMD_BUTTON, CMD_BUTTON, CMD_BUTTON, CMD_BUTTON, CMD_BUTTON, CMD_BUTTON,
    CMD_BUTTON, CMD_ENCODER, CMD_PROFILING
  };

  localparam arg_kind_e KW_ARG [KW_NUM] = '{
    ARG_NONE, ARG_NONE, ARG_UNSIGNED, ARG_UNSIGNED, ARG_UNSIGNED,
    ARG_BUTTON, ARG_BUTTON, ARG_BUTTON, ARG_BUTTON, ARG_BUTTON, ARG_BUTTON,
    ARG_BUTTON, ARG_SIGNED, ARG_NONE
  };

  localparam logic [2:0] KW_BTN [KW_NUM] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5,
    3'd6, 3'd0, 3'd0
  };

  typedef struct packed {
    logic clear;
    logic feed;
  } kw_ctl_t;

  typedef struct packed {
    logic                hit;
    logic [KW_IDX_W-1:0] idx;
  } kw_hit_t;

  typedef struct packed {
    logic clear;
    logic feed;
    logic finish;
  } num_ctl_t;

  typedef struct packed {
    logic [31:0] mag;
    logic        neg;
    logic        ovf;
  } num_val_t;

  // 31 marks a character that is no digit at all
  function automatic logic [4:0] digit_value(input logic [7:0] c);
    logic [4:0] d;
    d = 5'd31;
    if (c >= "0" && c <= "9") begin
      d = 5'(c - "0");
    end else if (c >= "a" && c <= "f") begin
      d = 5'(c - "a" + 8'd10);
    end else if (c >= "A" && c <= "F") begin
      d = 5'(c - "A" + 8'd10);
    end
    return d;
  endfunction

  function automatic logic [4:0] base_limit(input num_base_e b);
    logic [4:0] r;
    unique case (b)
      BASE_OCT:  r = 5'd8;
      BASE_DEC:  r = 5'd10;
      BASE_HEX:  r = 5'd16;
      BASE_NONE: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic kw_char_ok(input int unsigned k, input logic [KW_POS_W-1:0] p,
                                      input logic [7:0] c);
    int unsigned sh;
    logic        ok;
    ok = 1'b0;
    sh = 0;
    if (p < KW_LEN[k]) begin
      sh = 8 * (int'(KW_LEN[k]) - 1 - int'(p));
      ok = (KW_TEXT[k][sh +: 8] == c);
    end
    return ok;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ucl_in_if.sv -----
`default_nettype none

interface ucl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_char;
  logic       rx_error;

  modport source (output valid, output rx_char, output rx_error, input ready);
  modport sink   (input valid, input rx_char, input rx_error, output ready);
endinterface

`default_nettype wire

// ----- rtl/ucl_out_if.sv -----
`default_nettype none

interface ucl_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  echo_char;
  logic [3:0]  command;
  logic [31:0] argument;
  logic [1:0]  status;

  modport source (output valid, output kind, output echo_char, output command,
                  output argument, output status, input ready);
  modport sink   (input valid, input kind, input echo_char, input command,
                  input argument, input status, output ready);
endinterface

`default_nettype wire

// ----- rtl/ucl_keyword.sv -----
`default_nettype none

module ucl_keyword
  import ucl_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  kw_ctl_t       ctl_i,
  input  logic [7:0]    char_i,
  output kw_hit_t       hit_o
);

  logic [KW_NUM-1:0]   alive_q, alive_f, alive_d;
  logic [KW_POS_W-1:0] pos_q, pos_f, pos_d;
  kw_hit_t             hit;

  always_comb begin
    alive_f = alive_q;
    pos_f   = pos_q;
    if (ctl_i.feed) begin
      for (int unsigned k = 0; k < KW_NUM; k++) begin
        alive_f[k] = alive_q[k] & kw_char_ok(k, pos_q, char_i);
      end
      if (pos_q != '1) begin
        pos_f = pos_q + KW_POS_W'(1);
      end
    end
  end

  // first keyword still alive whose length equals the characters seen wins
  always_comb begin
    hit = '0;
    for (int unsigned k = 0; k < KW_NUM; k++) begin
      if (!hit.hit && alive_f[k] && (KW_LEN[k] == pos_f)) begin
        hit.hit = 1'b1;
        hit.idx = KW_IDX_W'(k);
      end
    end
  end

  assign hit_o   = hit;
  assign alive_d = ctl_i.clear ? '1 : alive_f;
  assign pos_d   = ctl_i.clear ? '0 : pos_f;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q <= '1;
      pos_q   <= '0;
    end else begin
      alive_q <= alive_d;
      pos_q   <= pos_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ucl_number.sv -----
`default_nettype none

module ucl_number
  import ucl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  num_ctl_t   ctl_i,
  input  logic [7:0] char_i,
  output num_val_t   val_o
);

  num_phase_e  phase_q, phase_f, phase_d;
  num_base_e   base_q, base_f, base_d;
  logic [31:0] mag_q, mag_f, mag_d;
  logic        neg_q, neg_f, neg_d;
  logic        ovf_q, ovf_f, ovf_d;

  logic [4:0]  dig;
  logic        is_space;
  num_phase_e  st_phase;
  num_base_e   st_base;
  logic        st_acc;
  logic        acc;
  logic [35:0] prod, sum;

  assign dig      = digit_value(char_i);
  assign is_space = (char_i == " ") || (char_i >= 8'd9 && char_i <= 8'd13);

  // first character after optional sign picks the base
  always_comb begin
    st_phase = NUM_DONE;
    st_base  = base_q;
    st_acc   = 1'b0;
    if (char_i == "0") begin
      st_phase = NUM_ZERO;
      st_base  = BASE_OCT;
    end else if (dig < 5'd10) begin
      st_phase = NUM_DIGITS;
      st_base  = BASE_DEC;
      st_acc   = 1'b1;
    end
  end

  always_comb begin
    phase_f = phase_q;
    base_f  = base_q;
    neg_f   = neg_q;
    acc     = 1'b0;
    if (ctl_i.feed) begin
      unique case (phase_q)
        NUM_SIGN: begin
          if (is_space) begin
            phase_f = NUM_SIGN;
          end else if (char_i == "+") begin
            phase_f = NUM_AFTER_SIGN;
          end else if (char_i == "-") begin
            phase_f = NUM_AFTER_SIGN;
            neg_f   = 1'b1;
          end else begin
            phase_f = st_phase;
            base_f  = st_base;
            acc     = st_acc;
          end
        end
        NUM_AFTER_SIGN: begin
          phase_f = st_phase;
          base_f  = st_base;
          acc     = st_acc;
        end
        NUM_ZERO: begin
          if (char_i == "x" || char_i == "X") begin
            phase_f = NUM_HEX_FIRST;
            base_f  = BASE_HEX;
          end else if (dig < 5'd8) begin
            phase_f = NUM_DIGITS;
            acc     = 1'b1;
          end else begin
            phase_f = NUM_DONE;
          end
        end
        NUM_HEX_FIRST: begin
          if (dig < 5'd16) begin
            phase_f = NUM_DIGITS;
            acc     = 1'b1;
          end else begin
            phase_f = NUM_DONE;
          end
        end
        NUM_DIGITS: begin
          if (dig < base_limit(base_q)) begin
            acc = 1'b1;
          end else begin
            phase_f = NUM_DONE;
          end
        end
        default: begin
          phase_f = NUM_DONE;
        end
      endcase
    end
  end

  // magnitude * base + digit, bases by shift and add
  always_comb begin
    unique case (base_f)
      BASE_OCT:  prod = {1'b0, mag_q, 3'b000};
      BASE_DEC:  prod = {1'b0, mag_q, 3'b000} + {3'b000, mag_q, 1'b0};
      BASE_HEX:  prod = {mag_q, 4'b0000};
      BASE_NONE: prod = '0;
    endcase
    sum   = prod + 36'(dig);
    mag_f = mag_q;
    ovf_f = ovf_q;
    if (acc && !ovf_q) begin
      if (sum[35:32] != 4'd0) begin
        ovf_f = 1'b1;
      end else begin
        mag_f = sum[31:0];
      end
    end
  end

  assign val_o = '{mag: mag_f, neg: neg_f, ovf: ovf_f};

  always_comb begin
    phase_d = phase_f;
    base_d  = base_f;
    mag_d   = mag_f;
    neg_d   = neg_f;
    ovf_d   = ovf_f;
    if (ctl_i.clear) begin
      phase_d = NUM_SIGN;
      base_d  = BASE_NONE;
      mag_d   = '0;
      neg_d   = 1'b0;
      ovf_d   = 1'b0;
    end else if (ctl_i.finish) begin
      phase_d = NUM_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= NUM_SIGN;
      base_q  <= BASE_NONE;
      mag_q   <= '0;
      neg_q   <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      base_q  <= base_d;
      mag_q   <= mag_d;
      neg_q   <= neg_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/uart_command_line_decoder.sv -----
// UART command line decoder.
// in_if carries one received character per item (rx_char, rx_error). Items
// with rx_error set are dropped. With echo_mode set, each character comes
// back on out_if as an echo item. Otherwise characters are collected into a
// message and, at the end or line-feed character or at MAX_MESSAGE_LENGTH
// characters, one command report item is produced (command, argument,
// status). Messages without any word produce nothing.
// Pipeline: input register, decode stage, output register. An item
// is registered in each in turn; one item is taken every cycle when
// out_if keeps ready high.
// Configuration goes through cfg_we_i / cfg_idx_i / cfg_data_i, one write
// per cycle, only while no item is in flight (a rule for the user that the
// block does not enforce). Reset clears all stages, the message state and
// sets the registers to echo on, separator 32, end 13, line feed 10.
// When out_if stalls, the output and decode stages hold and fill up; ready
// on in_if drops once the input register is occupied as well.
`default_nettype none

module uart_command_line_decoder
  import ucl_pkg::*;
#(
  parameter int unsigned MAX_MESSAGE_LENGTH = MAX_MSG_LEN_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ucl_in_if.sink     in_if,
  ucl_out_if.source  out_if,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i
);

  localparam int unsigned LenW = $clog2(MAX_MESSAGE_LENGTH + 1);

  // configuration
  logic       echo_q;
  logic [7:0] sep_q, end_q, lf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_q <= ECHO_MODE_RST;
      sep_q  <= WORD_SEP_RST;
      end_q  <= MSG_END_RST;
      lf_q   <= LINE_FEED_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ECHO_MODE: echo_q <= cfg_data_i[0];
        CFG_WORD_SEP:  sep_q  <= cfg_data_i;
        CFG_MSG_END:   end_q  <= cfg_data_i;
        CFG_LINE_FEED: lf_q   <= cfg_data_i;
      endcase
    end
  end

  // stage handshake
  logic v1_q, v2_q, out_valid_q;
  logic adv1, adv2;

  assign adv2        = !out_valid_q || out_if.ready;
  assign adv1        = !v2_q || adv2;
  assign in_if.ready = !v1_q || adv1;

  // input register
  logic [7:0] c1_q;
  logic       e1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (in_if.ready) begin
      v1_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      c1_q <= in_if.rx_char;
      e1_q <= in_if.rx_error;
    end
  end

  // decode stage
  logic            step, dstep;
  logic            between_q, between_n;
  logic [1:0]      wc_q, wc_n;
  logic [LenW-1:0] len_q, len_n;
  logic            is_sep, is_end, done, report, produce;
  logic            finish, kw_feed, num_feed;
  kw_ctl_t         kw_ctl;
  num_ctl_t        num_ctl;
  kw_hit_t         kw_hit;
  num_val_t        num_val;

  assign step  = v1_q && adv1 && !e1_q;
  assign dstep = step && !echo_q;

  assign is_sep = (c1_q == sep_q);
  assign is_end = (c1_q == end_q) || (c1_q == lf_q);

  always_comb begin
    between_n = between_q;
    wc_n      = wc_q;
    finish    = 1'b0;
    kw_feed   = 1'b0;
    num_feed  = 1'b0;
    if (is_sep) begin
      // a separator right after the second word closes the number
      finish    = (wc_q == 2'd2) && !between_q;
      between_n = 1'b1;
    end else if (!is_end) begin
      if (between_q) begin
        between_n = 1'b0;
        if (wc_q != 2'd2) begin
          wc_n = wc_q + 2'd1;
        end
      end
      kw_feed  = (wc_n == 2'd1);
      num_feed = (wc_n == 2'd2);
    end
  end

  assign len_n   = len_q + LenW'(1);
  assign done    = is_end || (len_n == LenW'(MAX_MESSAGE_LENGTH));
  assign report  = done && (wc_n != 2'd0);
  assign produce = step && (echo_q || report);

  assign kw_ctl  = '{clear: dstep && done, feed: dstep && kw_feed};
  assign num_ctl = '{clear: dstep && done, feed: dstep && num_feed,
                     finish: dstep && finish};

  ucl_keyword u_keyword (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (kw_ctl),
    .char_i (c1_q),
    .hit_o  (kw_hit)
  );

  ucl_number u_number (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (num_ctl),
    .char_i (c1_q),
    .val_o  (num_val)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      between_q <= 1'b1;
      wc_q      <= '0;
      len_q     <= '0;
    end else if (dstep) begin
      if (done) begin
        between_q <= 1'b1;
        wc_q      <= '0;
        len_q     <= '0;
      end else begin
        between_q <= between_n;
        wc_q      <= wc_n;
        len_q     <= len_n;
      end
    end
  end

  // decode stage result register
  logic       s2_kind_q;
  logic [7:0] s2_char_q;
  kw_hit_t    s2_hit_q;
  logic       s2_has_arg_q;
  num_val_t   s2_num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv1) begin
      v2_q <= produce;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && produce) begin
      s2_kind_q    <= echo_q ? KIND_ECHO : KIND_REPORT;
      s2_char_q    <= c1_q;
      s2_hit_q     <= kw_hit;
      s2_has_arg_q <= (wc_n == 2'd2);
      s2_num_q     <= num_val;
    end
  end

  // report formatting
  logic [7:0]  echo_char_d;
  logic [3:0]  command_d;
  logic [31:0] argument_d;
  logic [1:0]  status_d;
  logic [31:0] signed_val;
  logic        sat;

  assign signed_val = s2_num_q.neg ? (32'd0 - s2_num_q.mag) : s2_num_q.mag;
  assign sat = s2_num_q.ovf ||
               (s2_num_q.neg ? (s2_num_q.mag > 32'h8000_0000)
                             : (s2_num_q.mag > 32'h7FFF_FFFF));

  always_comb begin
    echo_char_d = '0;
    command_d   = CMD_NONE;
    argument_d  = '0;
    status_d    = STATUS_OK;
    if (s2_kind_q == KIND_ECHO) begin
      echo_char_d = s2_char_q;
    end else if (!s2_hit_q.hit) begin
      status_d = STATUS_UNKNOWN;
    end else begin
      command_d = KW_CMD[s2_hit_q.idx];
      unique case (KW_ARG[s2_hit_q.idx])
        ARG_NONE: begin
          argument_d = '0;
        end
        ARG_BUTTON: begin
          argument_d = 32'(KW_BTN[s2_hit_q.idx]);
        end
        ARG_UNSIGNED: begin
          if (!s2_has_arg_q) begin
            status_d = STATUS_MISSING;
          end else begin
            argument_d = s2_num_q.ovf ? 32'hFFFF_FFFF : signed_val;
          end
        end
        ARG_SIGNED: begin
          if (!s2_has_arg_q) begin
            status_d = STATUS_MISSING;
          end else if (sat) begin
            argument_d = s2_num_q.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
          end else begin
            argument_d = signed_val;
          end
        end
      endcase
    end
  end

  // output register
  logic        out_kind_q;
  logic [7:0]  out_char_q;
  logic [3:0]  out_cmd_q;
  logic [31:0] out_arg_q;
  logic [1:0]  out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv2) begin
      out_valid_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2 && v2_q) begin
      out_kind_q   <= s2_kind_q;
      out_char_q   <= echo_char_d;
      out_cmd_q    <= command_d;
      out_arg_q    <= argument_d;
      out_status_q <= status_d;
    end
  end

  assign out_if.valid     = out_valid_q;
  assign out_if.kind      = out_kind_q;
  assign out_if.echo_char = out_char_q;
  assign out_if.command   = out_cmd_q;
  assign out_if.argument  = out_arg_q;
  assign out_if.status    = out_status_q;

endmodule

`default_nettype wire

// ----- rtl/ucl_checker.sv -----
`default_nettype none

module ucl_checker
  import ucl_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_kind_i,
  input logic [7:0]  out_echo_char_i,
  input logic [3:0]  out_command_i,
  input logic [31:0] out_argument_i,
  input logic [1:0]  out_status_i
);

  // stalled result item stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_kind_i) &&
      $stable(out_echo_char_i) && $stable(out_command_i) &&
      $stable(out_argument_i) && $stable(out_status_i))
    else $error("result item changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i == KIND_ECHO) |->
      (out_command_i == CMD_NONE) && (out_argument_i == 32'd0) &&
      (out_status_i == STATUS_OK))
    else $error("echo item carries report fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i == KIND_REPORT) && (out_status_i == STATUS_UNKNOWN) |->
      (out_command_i == CMD_NONE) && (out_argument_i == 32'd0) &&
      (out_echo_char_i == 8'd0))
    else $error("unknown command report not cleared");

  // only commands that take a number can lack one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i == KIND_REPORT) && (out_status_i == STATUS_MISSING) |->
      (out_argument_i == 32'd0) &&
      ((out_command_i == CMD_VOLTAGE) || (out_command_i == CMD_CURRENT) ||
       (out_command_i == CMD_LIMIT) || (out_command_i == CMD_ENCODER)))
    else $error("missing argument on a command without argument");

endmodule

bind uart_command_line_decoder ucl_checker u_ucl_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_if.valid),
  .out_ready_i     (out_if.ready),
  .out_kind_i      (out_if.kind),
  .out_echo_char_i (out_if.echo_char),
  .out_command_i   (out_if.command),
  .out_argument_i  (out_if.argument),
  .out_status_i    (out_if.status)
);

`default_nettype wire

// ----- bench/ucl_line_checker.sv -----
`timescale 1ns / 100ps

module ucl_line_checker
  import ucl_pkg::*;
#(
  parameter int unsigned MAX_MESSAGE_LENGTH = MAX_MSG_LEN_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ucl_in_if          in_mon,
  ucl_out_if         out_mon,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  output int         mismatch_count_o,
  output int         pending_o
);

  typedef struct packed {
    logic        kind;
    logic [7:0]  echo_char;
    logic [3:0]  command;
    logic [31:0] argument;
    logic [1:0]  status;
  } reply_t;

  localparam int    KW_COUNT   = 14;
  localparam string UNDERSCORE = "_";

  string kw_word [KW_COUNT] = '{
    "on", "off", {"set", UNDERSCORE, "voltage"}, {"set", UNDERSCORE, "current"},
    {"set", UNDERSCORE, "current_limit"}, "btn_esc", "btn_ok", {"btn", UNDERSCORE, "left"},
    {"btn", UNDERSCORE, "right"}, "btn_on", "btn_off", {"push", UNDERSCORE, "encoder"},
    {"encoder", UNDERSCORE, "delta"}, {"get_time", UNDERSCORE, "profiling"}
  };
  logic [3:0] kw_cmd [KW_COUNT] = '{
    CMD_ON, CMD_OFF, CMD_VOLTAGE, CMD_CURRENT, CMD_LIMIT,
    CMD_BUTTON, CMD_BUTTON, CMD_BUTTON, CMD_BUTTON, CMD_BUTTON, CMD_BUTTON,
    CMD_BUTTON, CMD_ENCODER, CMD_PROFILING
  };
  arg_kind_e kw_arg [KW_COUNT] = '{
    ARG_NONE, ARG_NONE, ARG_UNSIGNED, ARG_UNSIGNED, ARG_UNSIGNED,
    ARG_BUTTON, ARG_BUTTON, ARG_BUTTON, ARG_BUTTON, ARG_BUTTON, ARG_BUTTON,
    ARG_BUTTON, ARG_SIGNED, ARG_NONE
  };
  logic [31:0] kw_btn [KW_COUNT] = '{0, 0, 0, 0, 0, 0, 1, 2, 3, 4, 5, 6, 0, 0};

  // register copies
  logic       echo_on;
  logic [7:0] sep_char;
  logic [7:0] end_char;
  logic [7:0] lf_char;

  // message state
  bit                  in_gap;
  logic [6:0]          line_len;
  logic [1:0]          words;
  logic [KW_COUNT-1:0] kw_alive;
  logic [4:0]          kw_pos;
  logic [63:0]         num_mag;
  int unsigned         num_base;
  num_phase_e          num_ph;
  bit                  num_neg;
  bit                  num_ovf;

  reply_t reply_queue [$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_count_o++;
  endtask

  task automatic clear_line();
    in_gap   = 1'b1;
    line_len = '0;
    words    = '0;
    kw_alive = '1;
    kw_pos   = '0;
    num_mag  = '0;
    num_base = 0;
    num_ph   = NUM_SIGN;
    num_neg  = 1'b0;
    num_ovf  = 1'b0;
  endtask

  task automatic keyword_char(input logic [7:0] c);
    for (int k = 0; k < KW_COUNT; k++) begin
      if (kw_pos >= kw_word[k].len() || kw_word[k][kw_pos] != c) begin
        kw_alive[k] = 1'b0;
      end
    end
    if (kw_pos < 5'd31) begin
      kw_pos++;
    end
  endtask

  function automatic int unsigned digit_of(input logic [7:0] c);
    int unsigned d;
    d = 99;
    if (c >= "0" && c <= "9") begin
      d = 32'(c - "0");
    end else if (c >= "a" && c <= "f") begin
      d = c - "a" + 10;
    end else if (c >= "A" && c <= "F") begin
      d = c - "A" + 10;
    end
    return d;
  endfunction

  task automatic accumulate(input int unsigned d);
    logic [63:0] v;
    if (!num_ovf) begin
      v = num_mag * num_base + d;
      if (v > 64'hFFFF_FFFF) begin
        num_ovf = 1'b1;
      end else begin
        num_mag = v;
      end
    end
  endtask

  task automatic number_first(input logic [7:0] c);
    int unsigned d;
    d = digit_of(c);
    if (c == "0") begin
      num_ph   = NUM_ZERO;
      num_base = 8;
    end else if (d < 10) begin
      num_base = 10;
      accumulate(d);
      num_ph = NUM_DIGITS;
    end else begin
      num_ph = NUM_DONE;
    end
  endtask

  task automatic number_char(input logic [7:0] c);
    int unsigned d;
    d = digit_of(c);
    case (num_ph)
      NUM_SIGN: begin
        // leading white space is skipped
        if (!(c == " " || (c >= 8'd9 && c <= 8'd13))) begin
          if (c == "+") begin
            num_ph = NUM_AFTER_SIGN;
          end else if (c == "-") begin
            num_neg = 1'b1;
            num_ph  = NUM_AFTER_SIGN;
          end else begin
            number_first(c);
          end
        end
      end
      NUM_AFTER_SIGN: number_first(c);
      NUM_ZERO: begin
        if (c == "x" || c == "X") begin
          num_base = 16;
          num_ph   = NUM_HEX_FIRST;
        end else if (d < 8) begin
          accumulate(d);
          num_ph = NUM_DIGITS;
        end else begin
          num_ph = NUM_DONE;
        end
      end
      NUM_HEX_FIRST: begin
        if (d < 16) begin
          accumulate(d);
          num_ph = NUM_DIGITS;
        end else begin
          num_ph = NUM_DONE;
        end
      end
      NUM_DIGITS: begin
        if (d < num_base) begin
          accumulate(d);
        end else begin
          num_ph = NUM_DONE;
        end
      end
      default: num_ph = NUM_DONE;
    endcase
  endtask

  task automatic build_report(output reply_t r);
    int          found;
    logic [31:0] mag;
    found = -1;
    mag   = num_mag[31:0];
    r     = '0;
    r.kind = KIND_REPORT;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (found < 0 && kw_alive[k] && kw_word[k].len() == kw_pos) begin
        found = k;
      end
    end
    if (found < 0) begin
      r.status = STATUS_UNKNOWN;
    end else begin
      r.command = kw_cmd[found];
      case (kw_arg[found])
        ARG_BUTTON: r.argument = kw_btn[found];
        ARG_UNSIGNED: begin
          if (words < 2) begin
            r.status = STATUS_MISSING;
          end else if (num_ovf) begin
            r.argument = 32'hFFFF_FFFF;
          end else begin
            r.argument = num_neg ? -mag : mag;
          end
        end
        ARG_SIGNED: begin
          if (words < 2) begin
            r.status = STATUS_MISSING;
          end else if (num_ovf || (num_neg ? mag > 32'h8000_0000 : mag > 32'h7FFF_FFFF)) begin
            r.argument = num_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
          end else begin
            r.argument = num_neg ? -mag : mag;
          end
        end
        default: ;
      endcase
    end
  endtask

  // one accepted character without line error
  task automatic decode_char(input logic [7:0] c, output bit got, output reply_t r);
    bit at_end;
    got = 1'b0;
    r   = '0;
    if (echo_on) begin
      got         = 1'b1;
      r.kind      = KIND_ECHO;
      r.echo_char = c;
    end else begin
      at_end = (c == end_char) || (c == lf_char);
      // a separator that is also an end character splits first, then ends
      if (c == sep_char) begin
        if (words == 2 && !in_gap) begin
          num_ph = NUM_DONE;
        end
        in_gap = 1'b1;
      end else if (!at_end) begin
        if (in_gap) begin
          in_gap = 1'b0;
          if (words < 2) begin
            words++;
          end
        end
        if (words == 1) begin
          keyword_char(c);
        end else if (words == 2 && num_ph != NUM_DONE) begin
          number_char(c);
        end
      end
      line_len = line_len + 7'd1;
      if (at_end || line_len == MAX_MESSAGE_LENGTH) begin
        if (words != 0) begin
          got = 1'b1;
          build_report(r);
        end
        clear_line();
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    reply_t fresh;
    bit     got;
    if (!rst_ni) begin
      echo_on  = ECHO_MODE_RST;
      sep_char = WORD_SEP_RST;
      end_char = MSG_END_RST;
      lf_char  = LINE_FEED_RST;
      clear_line();
      reply_queue.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (reply_queue.size() == 0) begin
          report_mismatch("unexpected result, kind", 32'(out_mon.kind), '0);
        end else begin
          want = reply_queue.pop_front();
          if (out_mon.kind !== want.kind) begin
            report_mismatch("kind", 32'(out_mon.kind), 32'(want.kind));
          end
          if (out_mon.echo_char !== want.echo_char) begin
            report_mismatch("echo_char", 32'(out_mon.echo_char), 32'(want.echo_char));
          end
          if (out_mon.command !== want.command) begin
            report_mismatch("command", 32'(out_mon.command), 32'(want.command));
          end
          if (out_mon.argument !== want.argument) begin
            report_mismatch("argument", out_mon.argument, want.argument);
          end
          if (out_mon.status !== want.status) begin
            report_mismatch("status", 32'(out_mon.status), 32'(want.status));
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ECHO_MODE: echo_on  = cfg_data_i[0];
          CFG_WORD_SEP:  sep_char = cfg_data_i;
          CFG_MSG_END:   end_char = cfg_data_i;
          CFG_LINE_FEED: lf_char  = cfg_data_i;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready && !in_mon.rx_error) begin
        decode_char(in_mon.rx_char, got, fresh);
        if (got) begin
          reply_queue.push_back(fresh);
        end
      end
    end
    pending_o = reply_queue.size();
  end

endmodule

// ----- bench/tb_uart_command_line_decoder.sv -----
`timescale 1ns / 100ps

module tb_uart_command_line_decoder;
  import ucl_pkg::*;

  localparam int    KW_COUNT   = 14;
  localparam int    SETTLE     = 8;
  localparam string UNDERSCORE = "_";

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [7:0] cfg_data_i;
  int         mismatch_count;
  int         replies_pending;

  // when set, neither side idles
  bit         calm;
  logic [7:0] sep_char;
  logic [7:0] end_char;
  logic [7:0] lf_char;

  string kw_pool [KW_COUNT] = '{
    "on", "off", {"set", UNDERSCORE, "voltage"}, {"set", UNDERSCORE, "current"},
    {"set", UNDERSCORE, "current_limit"}, "btn_esc", "btn_ok", {"btn", UNDERSCORE, "left"},
    {"btn", UNDERSCORE, "right"}, "btn_on", "btn_off", {"push", UNDERSCORE, "encoder"},
    {"encoder", UNDERSCORE, "delta"}, {"get_time", UNDERSCORE, "profiling"}
  };

  string directed_text [$] = {
    "on", "off", {"set", UNDERSCORE, "voltage 12000"}, {"set", UNDERSCORE, "current 0x1F"},
    {"set", UNDERSCORE, "current_limit 017"},
    "btn_esc", "btn_ok", {"btn", UNDERSCORE, "left"}, {"btn", UNDERSCORE, "right"},
    "btn_on", "btn_off",
    {"push", UNDERSCORE, "encoder"}, {"get_time", UNDERSCORE, "profiling"},
    {"encoder", UNDERSCORE, "delta -5"},
    {"encoder", UNDERSCORE, "delta 2147483648"}, {"encoder", UNDERSCORE, "delta -2147483649"},
    {"encoder", UNDERSCORE, "delta -2147483648"},
    {"set", UNDERSCORE, "voltage"}, {"set", UNDERSCORE, "voltage 4294967296"},
    {"set", UNDERSCORE, "voltage -1"}, {"set", UNDERSCORE, "current 0X"},
    {"set", UNDERSCORE, "current \t+0xfFfF"}, "bogus 12", "", "   ", "  btn_ok  ",
    "on 5 extra", "of"
  };

  ucl_in_if  in_ch ();
  ucl_out_if out_ch ();

  uart_command_line_decoder u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  ucl_line_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_mon           (in_ch),
    .out_mon          (out_ch),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .pending_o        (replies_pending)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_ch.ready <= calm || ($urandom_range(0, 99) >= 11);
  end

  task automatic send_item(input logic [7:0] c, input logic e);
    while (!calm && $urandom_range(0, 99) < 11) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.rx_char  <= c;
    in_ch.rx_error <= e;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // a dropped character with a line error now and then
  task automatic send_bytes(input logic [7:0] q [$]);
    foreach (q[i]) begin
      if ($urandom_range(0, 99) < 3) begin
        send_item(8'($urandom_range(0, 255)), 1'b1);
      end
      send_item(q[i], 1'b0);
    end
  endtask

  function automatic void add_text(ref logic [7:0] q [$], input string s);
    for (int i = 0; i < s.len(); i++) begin
      q.push_back(s[i]);
    end
  endfunction

  task automatic send_line(input string s, input logic [7:0] term);
    logic [7:0] q [$];
    add_text(q, s);
    q.push_back(term);
    send_bytes(q);
  endtask

  task automatic drain_replies();
    in_ch.valid <= 1'b0;
    while (replies_pending != 0) @(negedge clk_i);
    // characters that give no result may still be in the pipeline
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic apply_setting(input logic echo, input logic [7:0] sep,
                               input logic [7:0] term, input logic [7:0] lf);
    drain_replies();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_ECHO_MODE;
    cfg_data_i <= {7'd0, echo};
    @(negedge clk_i);
    cfg_idx_i  <= CFG_WORD_SEP;
    cfg_data_i <= sep;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_MSG_END;
    cfg_data_i <= term;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_LINE_FEED;
    cfg_data_i <= lf;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sep_char = sep;
    end_char = term;
    lf_char  = lf;
  endtask

  function automatic string number_text();
    string       s;
    string       h;
    logic [31:0] v;
    int          sel;
    v = $urandom();
    if ($urandom_range(0, 2) == 0) begin
      v = $urandom_range(0, 999);
    end
    s = ($urandom_range(0, 5) == 0) ? "\t" : "";
    sel = $urandom_range(0, 5);
    if (sel == 1) begin
      s = {s, "+"};
    end else if (sel == 2) begin
      s = {s, "-"};
    end
    case ($urandom_range(0, 10))
      0, 1, 2, 3: s = {s, $sformatf("%0d", v)};
      4, 5: begin
        h = $sformatf("0x%0h", v);
        if ($urandom_range(0, 1) == 1) begin
          h = h.toupper();
        end
        s = {s, h};
      end
      6:  s = {s, $sformatf("0%0o", v)};
      7:  s = {s, $sformatf("42949672%0d", $urandom_range(90, 99))};
      8:  s = {s, $sformatf("21474836%0d", $urandom_range(45, 50))};
      9:  s = {s, $sformatf("0x1%08h", v)};
      default: s = {s, "0x"};
    endcase
    if ($urandom_range(0, 5) == 0) begin
      s = {s, $sformatf("%c", 8'($urandom_range(33, 126)))};
    end
    return s;
  endfunction

  task automatic random_lines(input int quota);
    int         sent;
    int         form;
    string      kw;
    logic [7:0] q [$];
    sent = 0;
    while (sent < quota) begin
      q.delete();
      form = $urandom_range(0, 99);
      if ($urandom_range(0, 7) == 0) begin
        q.push_back(sep_char);
      end
      if (form < 75) begin
        kw = kw_pool[$urandom_range(0, KW_COUNT - 1)];
        if ($urandom_range(0, 9) == 0) begin
          kw = kw.substr(0, kw.len() - 2);
        end else if ($urandom_range(0, 9) == 0) begin
          kw = {kw, "s"};
        end
        add_text(q, kw);
        if ($urandom_range(0, 4) != 0) begin
          repeat ($urandom_range(1, 2)) q.push_back(sep_char);
          add_text(q, number_text());
          if ($urandom_range(0, 7) == 0) begin
            q.push_back(sep_char);
            add_text(q, "x1");
          end
        end
        if ($urandom_range(0, 7) == 0) begin
          q.push_back(sep_char);
        end
      end else if (form < 85) begin
        // long word that may run into the length limit
        repeat ($urandom_range(40, 70)) q.push_back(8'($urandom_range(33, 126)));
      end else begin
        repeat ($urandom_range(1, 20)) q.push_back(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 9) != 0) begin
        q.push_back(($urandom_range(0, 1) == 1) ? end_char : lf_char);
      end
      sent += q.size();
      send_bytes(q);
    end
  endtask

  task automatic random_echo(input int quota);
    repeat (quota) begin
      send_item(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
    end
  endtask

  initial begin
    logic [7:0] q [$];
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_ECHO_MODE;
    cfg_data_i     = '0;
    in_ch.valid    = 1'b0;
    in_ch.rx_char  = '0;
    in_ch.rx_error = 1'b0;
    calm           = 1'b0;
    sep_char       = WORD_SEP_RST;
    end_char       = MSG_END_RST;
    lf_char        = LINE_FEED_RST;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // echo mode out of reset
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h41, 1'b1);
    send_item(8'h0D, 1'b0);
    send_item(8'h0A, 1'b0);
    random_echo(60);

    apply_setting(1'b0, 8'd32, 8'd13, 8'd10);
    foreach (directed_text[i]) begin
      send_line(directed_text[i], (i % 4 == 1) ? lf_char : end_char);
    end
    // zero byte inside a keyword
    q.delete();
    add_text(q, "o");
    q.push_back(8'h00);
    add_text(q, "n");
    q.push_back(end_char);
    send_bytes(q);
    // no terminator: the length limit ends it
    q.delete();
    add_text(q, {"set", UNDERSCORE, "voltage 1"});
    repeat (60) add_text(q, "9");
    send_bytes(q);
    random_lines(120);
    drain_replies();
    random_lines(120);

    // separator equal to the end character, no idling in this phase
    apply_setting(1'b0, 8'd13, 8'd13, 8'd255);
    calm = 1'b1;
    send_line({"set", UNDERSCORE, "voltage"}, end_char);
    random_lines(180);
    calm = 1'b0;

    apply_setting(1'b0, 8'd0, 8'd255, 8'd0);
    random_lines(180);

    apply_setting(1'b1, 8'd255, 8'd0, 8'd255);
    random_echo(150);

    apply_setting(1'b0, 8'd44, 8'd10, 8'd10);
    random_lines(180);

    apply_setting(1'b0, 8'd255, 8'd0, 8'd13);
    random_lines(90);

    drain_replies();
    if (mismatch_count == 0) begin
      $display("uart_command_line_decoder verification clean");
    end else begin
      $display("uart_command_line_decoder verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("uart_command_line_decoder verification failed");
    $finish;
  end

endmodule
